// ===== design/pee_pkg.sv =====
// Shared types, constants and character codes for the expression evaluator.
// Used by the front end, the back end and the top level.
package pee_pkg;
  localparam int STACK_DEPTH = 16;
  localparam int VALUE_WIDTH = 32;
  localparam int SP_W = $clog2(STACK_DEPTH);
  localparam int CNT_W = $clog2(STACK_DEPTH + 1);
  localparam int FQ_DEPTH = 2;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_LPAR = 8'h28;
  localparam logic [7:0] CH_RPAR = 8'h29;
  localparam logic [7:0] CH_MUL = 8'h2a;
  localparam logic [7:0] CH_ADD = 8'h2b;
  localparam logic [7:0] CH_SUB = 8'h2d;
  localparam logic [7:0] CH_DIV = 8'h2f;
  localparam logic [7:0] CH_REM = 8'h25;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0, OP_SUB = 3'd1, OP_MUL = 3'd2, OP_DIV = 3'd3, OP_REM = 3'd4
  } op_t;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_UNDER = 3'd1;
  localparam logic [2:0] ST_OVER = 3'd2;
  localparam logic [2:0] ST_DIVZERO = 3'd3;
  localparam logic [2:0] ST_DIVOVF = 3'd4;
  localparam logic [2:0] ST_BADCHAR = 3'd5;

  // Token kinds handed from the classifier to the executor.
  typedef enum logic [2:0] {
    TK_NONE = 3'd0, TK_DIGIT = 3'd1, TK_OP = 3'd2, TK_MINUS = 3'd3,
    TK_CLOSE = 3'd4, TK_SEP = 3'd5, TK_BAD = 3'd6
  } tok_t;

  typedef struct packed {
    tok_t kind;
    op_t op;
    logic [3:0] digit;
    logic space;
    logic last;
  } token_t;

  localparam int TOKEN_W = $bits(token_t);
endpackage

// ===== design/pee_ram.sv =====
// Generic RAM with one write port and one read port, registered read.
// No package dependency.
module pee_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== design/pee_front.sv =====
// Front end: classifies characters into tokens and queues them.
// Depends on pee_pkg.
module pee_front import pee_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  output logic       full,
  input  logic [7:0] ch,
  input  logic       last,
  output logic       tok_valid,
  output token_t     tok,
  input  logic       tok_take
);
  localparam int QP_W = $clog2(FQ_DEPTH);

  token_t q_r [FQ_DEPTH];
  logic [QP_W-1:0] wp_r, rp_r;
  logic [QP_W:0] cnt_r;
  token_t t;
  logic acc, take;

  always_comb begin
    t.kind = TK_BAD;
    t.op = OP_ADD;
    t.digit = 4'(ch - CH_ZERO);
    t.space = (ch == CH_SPACE);
    t.last = last;
    if (ch >= CH_ZERO && ch <= CH_NINE) begin
      t.kind = TK_DIGIT;
    end else begin
      case (ch)
        CH_SPACE, CH_LPAR: t.kind = TK_SEP;
        CH_ADD: begin t.kind = TK_OP; t.op = OP_ADD; end
        CH_MUL: begin t.kind = TK_OP; t.op = OP_MUL; end
        CH_DIV: begin t.kind = TK_OP; t.op = OP_DIV; end
        CH_REM: begin t.kind = TK_OP; t.op = OP_REM; end
        CH_SUB: t.kind = TK_MINUS;
        CH_RPAR: t.kind = TK_CLOSE;
        default: t.kind = TK_BAD;
      endcase
    end
  end

  assign full = (cnt_r == (QP_W+1)'(FQ_DEPTH));
  assign acc = push && !full;
  assign tok_valid = (cnt_r != '0);
  assign take = tok_take && tok_valid;
  assign tok = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (acc) begin
      q_r[wp_r] <= t;
    end
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (acc) wp_r <= (wp_r == QP_W'(FQ_DEPTH-1)) ? '0 : wp_r + 1'b1;
      if (take) rp_r <= (rp_r == QP_W'(FQ_DEPTH-1)) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_r + (QP_W+1)'(acc) - (QP_W+1)'(take);
    end
  end
endmodule

// ===== design/pee_div.sv =====
// Radix-2 restoring divider on magnitudes, one quotient bit per cycle.
// Depends on pee_pkg.
module pee_div import pee_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [VALUE_WIDTH-1:0] dvd,
  input  logic [VALUE_WIDTH-1:0] dvs,
  output logic                   done,
  output logic [VALUE_WIDTH-1:0] quo,
  output logic [VALUE_WIDTH-1:0] rem
);
  localparam int CW = $clog2(VALUE_WIDTH + 1);
  logic [VALUE_WIDTH-1:0] q_r, d_r;
  logic [VALUE_WIDTH:0] r_r, trial;
  logic [CW-1:0] n_r;
  logic busy_r;

  assign trial = {r_r[VALUE_WIDTH-1:0], q_r[VALUE_WIDTH-1]} - {1'b0, d_r};
  assign quo = q_r;
  assign rem = r_r[VALUE_WIDTH-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        q_r <= dvd;
        d_r <= dvs;
        r_r <= '0;
        n_r <= CW'(VALUE_WIDTH);
      end else if (busy_r) begin
        if (trial[VALUE_WIDTH]) begin
          r_r <= {r_r[VALUE_WIDTH-1:0], q_r[VALUE_WIDTH-1]};
          q_r <= {q_r[VALUE_WIDTH-2:0], 1'b0};
        end else begin
          r_r <= trial;
          q_r <= {q_r[VALUE_WIDTH-2:0], 1'b1};
        end
        n_r <= n_r - 1'b1;
        if (n_r == CW'(1)) begin
          busy_r <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

// ===== design/pee_back.sv =====
// Back end: executes tokens on the value and operator stacks.
// Depends on pee_pkg, pee_ram and pee_div.
module pee_back import pee_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        tok_valid,
  input  token_t      tok,
  output logic        tok_take,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] value,
  output logic [2:0]  status
);
  localparam logic [VALUE_WIDTH-1:0] VSIGN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

  typedef enum logic [3:0] {
    S_TOK, S_RD1, S_RD2, S_EXEC, S_MUL, S_DIV, S_PUSHR, S_FIN, S_FINRD
  } state_t;

  state_t st_r;
  logic [CNT_W-1:0] vc_r, oc_r;
  logic [VALUE_WIDTH-1:0] acc_r, a_r, b_r, res_r;
  logic innum_r, neg_r, minus_r;
  logic [2:0] err_r;
  logic last_r;
  op_t op_r;
  logic [31:0] oval_r;
  logic [2:0] ostat_r;
  logic ofull_r;

  logic v_we, o_we;
  logic [SP_W-1:0] v_addr, v_raddr, o_addr, o_raddr;
  logic [VALUE_WIDTH-1:0] v_wdata, v_rdata;
  logic [2:0] o_rdata;
  logic [2:0] o_wdata;

  logic dstart, ddone;
  logic [VALUE_WIDTH-1:0] dq, dr, ma, mb;

  pee_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(STACK_DEPTH)) u_vram (
    .clk, .we(v_we), .addr(v_addr), .wdata(v_wdata), .raddr(v_raddr), .rdata(v_rdata)
  );
  pee_ram #(.WIDTH(3), .DEPTH(STACK_DEPTH)) u_oram (
    .clk, .we(o_we), .addr(o_addr), .wdata(o_wdata), .raddr(o_raddr), .rdata(o_rdata)
  );

  assign ma = a_r[VALUE_WIDTH-1] ? -a_r : a_r;
  assign mb = b_r[VALUE_WIDTH-1] ? -b_r : b_r;
  pee_div u_div (
    .clk, .rst_n, .start(dstart), .dvd(ma), .dvs(mb), .done(ddone), .quo(dq), .rem(dr)
  );

  assign empty = !ofull_r;
  assign value = oval_r;
  assign status = ostat_r;

  // Full-width numeric of the closed literal.
  logic [VALUE_WIDTH-1:0] litv, acc10;
  assign litv = neg_r ? -acc_r : acc_r;
  assign acc10 = (acc_r << 3) + (acc_r << 1);

  // Token step: combinational decisions on one token.
  logic tk_go, tk_hold, fin_go;
  assign tk_go = (st_r == S_TOK) && tok_valid;
  // Hold the token in the queue after closing a literal or pushing a pending sub.
  assign tk_hold = (err_r == ST_OK) && (tok.kind != TK_DIGIT) &&
                   ((minus_r && !tok.space && oc_r < CNT_W'(STACK_DEPTH)) ||
                    (!minus_r && innum_r && vc_r < CNT_W'(STACK_DEPTH)));
  assign tok_take = tk_go && !tk_hold;
  assign fin_go = (st_r == S_FINRD) && !last_r && (!ofull_r || pop);

  always_comb begin
    v_we = 1'b0;
    o_we = 1'b0;
    v_addr = vc_r[SP_W-1:0];
    v_wdata = litv;
    o_addr = oc_r[SP_W-1:0];
    o_wdata = OP_SUB;
    v_raddr = vc_r[SP_W-1:0] - 1'b1;
    o_raddr = oc_r[SP_W-1:0] - 1'b1;
    dstart = 1'b0;
    if (st_r == S_RD1) v_raddr = vc_r[SP_W-1:0] - SP_W'(2);
    if (st_r == S_MUL && (op_r == OP_DIV || op_r == OP_REM) && b_r != '0 &&
        !(a_r == VSIGN && b_r == '1)) dstart = 1'b1;
    if (st_r == S_PUSHR) begin
      v_we = (vc_r < CNT_W'(STACK_DEPTH));
      v_wdata = res_r;
    end
    if (tk_go && err_r == ST_OK) begin
      if (minus_r) begin
        if (tok.kind != TK_DIGIT) begin
          o_we = (oc_r < CNT_W'(STACK_DEPTH));
        end
      end else if (innum_r && tok.kind != TK_DIGIT) begin
        v_we = (vc_r < CNT_W'(STACK_DEPTH));
      end else if (tok.kind == TK_OP) begin
        o_we = (oc_r < CNT_W'(STACK_DEPTH));
        o_wdata = tok.op;
      end
    end
    if (st_r == S_FIN && err_r == ST_OK) begin
      if (minus_r) o_we = (oc_r < CNT_W'(STACK_DEPTH));
      else if (innum_r) v_we = (vc_r < CNT_W'(STACK_DEPTH));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_TOK;
      vc_r <= '0;
      oc_r <= '0;
      acc_r <= '0;
      innum_r <= 1'b0;
      neg_r <= 1'b0;
      minus_r <= 1'b0;
      err_r <= ST_OK;
      ofull_r <= 1'b0;
      last_r <= 1'b0;
    end else begin
      if (fin_go) ofull_r <= 1'b1;
      else if (pop && ofull_r) ofull_r <= 1'b0;
      case (st_r)
        S_TOK: begin
          if (tk_go) begin
            last_r <= tok.last;
            // Minus pending: a digit opens a negative literal, anything else pushes sub.
            if (err_r != ST_OK) begin
              if (tok.last) st_r <= S_FIN;
            end else if (minus_r) begin
              minus_r <= 1'b0;
              if (tok.kind == TK_DIGIT) begin
                innum_r <= 1'b1;
                neg_r <= 1'b1;
                acc_r <= VALUE_WIDTH'(tok.digit);
                if (tok.last) st_r <= S_FIN;
              end else begin
                if (oc_r < CNT_W'(STACK_DEPTH)) oc_r <= oc_r + 1'b1;
                else err_r <= ST_OVER;
                if (tok.space || oc_r >= CNT_W'(STACK_DEPTH)) begin
                  if (tok.last) st_r <= S_FIN;
                end else begin
                  st_r <= S_TOK;
                  // Re-run the same token as an ordinary one: hold it in the queue.
                end
              end
            end else if (innum_r && tok.kind == TK_DIGIT) begin
              acc_r <= acc10 + VALUE_WIDTH'(tok.digit);
              if (tok.last) st_r <= S_FIN;
            end else if (innum_r) begin
              innum_r <= 1'b0;
              neg_r <= 1'b0;
              acc_r <= '0;
              if (vc_r < CNT_W'(STACK_DEPTH)) begin
                vc_r <= vc_r + 1'b1;
              end else begin
                err_r <= ST_OVER;
                if (tok.last) st_r <= S_FIN;
              end
            end else begin
              case (tok.kind)
                TK_DIGIT: begin
                  innum_r <= 1'b1;
                  neg_r <= 1'b0;
                  acc_r <= VALUE_WIDTH'(tok.digit);
                end
                TK_OP: begin
                  if (oc_r < CNT_W'(STACK_DEPTH)) oc_r <= oc_r + 1'b1;
                  else err_r <= ST_OVER;
                end
                TK_MINUS: minus_r <= 1'b1;
                TK_SEP: ;
                TK_CLOSE: begin
                  if (oc_r == '0 || vc_r < CNT_W'(2)) err_r <= ST_UNDER;
                  else st_r <= S_RD1;
                end
                default: err_r <= ST_BADCHAR;
              endcase
              if (tok.last && !(tok.kind == TK_CLOSE && oc_r != '0 && vc_r >= CNT_W'(2)))
                st_r <= S_FIN;
            end
          end
        end
        S_RD1: st_r <= S_RD2;
        S_RD2: begin
          a_r <= v_rdata;
          op_r <= op_t'(o_rdata);
          oc_r <= oc_r - 1'b1;
          st_r <= S_EXEC;
        end
        S_EXEC: begin
          b_r <= v_rdata;
          vc_r <= vc_r - CNT_W'(2);
          st_r <= S_MUL;
        end
        S_MUL: begin
          case (op_r)
            OP_ADD: begin res_r <= a_r + b_r; st_r <= S_PUSHR; end
            OP_SUB: begin res_r <= a_r - b_r; st_r <= S_PUSHR; end
            OP_MUL: begin res_r <= a_r * b_r; st_r <= S_PUSHR; end
            OP_DIV, OP_REM: begin
              if (b_r == '0) begin
                err_r <= ST_DIVZERO;
                st_r <= last_r ? S_FIN : S_TOK;
              end else if (a_r == VSIGN && b_r == '1) begin
                err_r <= ST_DIVOVF;
                st_r <= last_r ? S_FIN : S_TOK;
              end else begin
                st_r <= S_DIV;
              end
            end
            default: begin res_r <= b_r; st_r <= S_PUSHR; end
          endcase
        end
        S_DIV: begin
          if (ddone) begin
            if (op_r == OP_DIV)
              res_r <= (a_r[VALUE_WIDTH-1] != b_r[VALUE_WIDTH-1]) ? -dq : dq;
            else
              res_r <= a_r[VALUE_WIDTH-1] ? -dr : dr;
            st_r <= S_PUSHR;
          end
        end
        S_PUSHR: begin
          if (vc_r < CNT_W'(STACK_DEPTH)) vc_r <= vc_r + 1'b1;
          else err_r <= ST_OVER;
          st_r <= last_r ? S_FIN : S_TOK;
        end
        S_FIN: begin
          if (err_r == ST_OK) begin
            if (minus_r) begin
              minus_r <= 1'b0;
              if (oc_r < CNT_W'(STACK_DEPTH)) oc_r <= oc_r + 1'b1;
              else err_r <= ST_OVER;
            end else if (innum_r) begin
              innum_r <= 1'b0;
              if (vc_r < CNT_W'(STACK_DEPTH)) vc_r <= vc_r + 1'b1;
              else err_r <= ST_OVER;
            end
          end
          st_r <= S_FINRD;
        end
        S_FINRD: begin
          // read issued with vc_r settled; data lands next cycle
          if (last_r) begin
            last_r <= 1'b0;
          end else if (fin_go) begin
            if (err_r != ST_OK) begin
              ostat_r <= err_r;
              oval_r <= '0;
            end else if (vc_r == '0) begin
              ostat_r <= ST_UNDER;
              oval_r <= '0;
            end else begin
              ostat_r <= ST_OK;
              oval_r <= 32'($signed(v_rdata));
            end
            vc_r <= '0;
            oc_r <= '0;
            acc_r <= '0;
            neg_r <= 1'b0;
            innum_r <= 1'b0;
            minus_r <= 1'b0;
            err_r <= ST_OK;
            st_r <= S_TOK;
          end
        end
        default: st_r <= S_TOK;
      endcase
    end
  end
endmodule

// ===== design/parenthesized_expression_evaluator.sv =====
// Top level: fully parenthesized integer expression evaluator, two stacks.
// Depends on pee_pkg, pee_front, pee_back.
// Accepts one character per cycle while the token queue is not full; a character ending
// a literal, or a non-space after '-', is held and re-run, and a ')' stalls the back end
// through its read, execute and push states, with the divider for '/' or '%'.
// Reset: rst_n empties the token queue, the result register and both stacks.
module parenthesized_expression_evaluator import pee_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_ch,
  input  logic        in_last,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] out_value,
  output logic [2:0]  out_status
);
  logic tok_valid, tok_take;
  token_t tok;

  pee_front u_front (
    .clk, .rst_n, .push, .full, .ch(in_ch), .last(in_last),
    .tok_valid, .tok, .tok_take
  );
  pee_back u_back (
    .clk, .rst_n, .tok_valid, .tok, .tok_take,
    .empty, .pop, .value(out_value), .status(out_status)
  );
endmodule

// ===== design/pee_checker.sv =====
// Port-level checker for the expression evaluator, bound to the top level.
// Depends on parenthesized_expression_evaluator ports only.
module pee_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        empty,
  input logic        pop,
  input logic [31:0] out_value,
  input logic [2:0]  out_status
);
  a_stat_range: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> out_status <= 3'd5) else $error("status out of range");
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_status != 3'd0) |-> out_value == 32'd0) else $error("value on error");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> !empty && $stable(out_value)) else $error("result dropped");
endmodule

bind parenthesized_expression_evaluator pee_checker u_pee_checker (
  .clk, .rst_n, .empty, .pop, .out_value, .out_status
);
